### sv/bmc_pkg.sv
// shared types and constants for the button multi-click classifier
`timescale 1ns / 1ps

package bmc_pkg;

    localparam int TimeW   = 32;
    localparam int CfgW    = 16;
    localparam int CountW  = 8;
    localparam int KindW   = 2;
    localparam int CfgIdxW = 8;
    localparam int InDataW  = 40;
    localparam int OutDataW = 8;

    localparam logic [CountW-1:0] CountMax = '1;

    typedef enum logic [KindW-1:0] {
        KIND_SINGLE = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_MULTI  = 2'd2
    } click_kind_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_MIN_CLICK = 8'd0,
        REG_MULTI_MAX = 8'd1
    } cfg_index_t;

    typedef struct packed {
        logic [CfgW-1:0] min_click_ms;
        logic [CfgW-1:0] multi_click_max_ms;
    } bmc_cfg_t;

    typedef struct packed {
        logic              accepted_level;
        logic [TimeW-1:0]  last_change_time;
        logic [CountW-1:0] click_count;
    } bmc_state_t;

    typedef struct packed {
        logic        valid;
        click_kind_t kind;
        logic        change;
    } bmc_result_t;

endpackage

### sv/button_multi_click_classifier.sv
// top level: input register, classifier state, result register, config port
// a poll is held in the input register; its result goes to the registered m_tdata output
// throughput: one poll per cycle unless s_tready stalls; the state update is one 32-bit subtract and compares
// s_tready drops only while the input register holds a poll whose result cannot
// move into a still-occupied result register
// reset: synchronous active-low aresetn clears state, counters and valid flags,
// and loads min_click_ms = 50 and multi_click_max_ms = 300
`timescale 1ns / 1ps

module button_multi_click_classifier import bmc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // [31:0] now_ms, [32] button_level, rest zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // [1:0] click_kind, rest zero
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgW-1:0]     cfg_data
);

    bmc_cfg_t    cfg;
    bmc_state_t  state_reg;
    bmc_state_t  state_next;
    bmc_result_t result;

    logic             in_valid_reg;
    logic [TimeW-1:0] in_now_reg;
    logic             in_level_reg;
    logic             out_valid_reg;
    click_kind_t      out_kind_reg;
    logic             out_free;
    logic             advance;

    bmc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bmc_core u_core (
        .cfg          (cfg),
        .state        (state_reg),
        .now_ms       (in_now_reg),
        .button_level (in_level_reg),
        .state_next   (state_next),
        .result       (result)
    );

    assign out_free = !out_valid_reg || m_tready;
    // polls without a result never wait on the output side
    assign advance  = in_valid_reg && (!result.valid || out_free);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW-KindW){1'b0}}, out_kind_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && result.valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_now_reg   <= s_tdata[TimeW-1:0];
            in_level_reg <= s_tdata[TimeW];
        end
        if (advance && result.valid) begin
            out_kind_reg <= result.kind;
        end
    end

    a_count_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.valid |=> state_reg.click_count == '0)
        else $error("click count not cleared after report");

    a_change_time: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.change |=> state_reg.last_change_time == $past(in_now_reg))
        else $error("change time not captured");

    a_no_report_on_change: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && result.change |-> !result.valid)
        else $error("report in the same poll as an accepted change");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'b11)
        else $error("illegal click kind");

endmodule

### sv/bmc_cfg.sv
// configuration register file for debounce and report timing
`timescale 1ns / 1ps

module bmc_cfg import bmc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data,
    output bmc_cfg_t           cfg
);

    bmc_cfg_t cfg_reg;
    bmc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MIN_CLICK: cfg_next.min_click_ms = cfg_data;
                REG_MULTI_MAX: cfg_next.multi_click_max_ms = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_click_ms <= CfgW'(50);
            cfg_reg.multi_click_max_ms <= CfgW'(300);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/bmc_core.sv
// per-poll debounce, click counting and burst classification logic
`timescale 1ns / 1ps

module bmc_core import bmc_pkg::*; (
    input  bmc_cfg_t         cfg,
    input  bmc_state_t       state,
    input  logic [TimeW-1:0] now_ms,
    input  logic             button_level,
    output bmc_state_t       state_next,
    output bmc_result_t      result
);

    logic [TimeW-1:0]  elapsed;
    logic              change;
    logic [CountW-1:0] count_upd;

    assign elapsed = now_ms - state.last_change_time;
    assign change  = (button_level != state.accepted_level)
                  && (elapsed > {{(TimeW-CfgW){1'b0}}, cfg.min_click_ms});

    always_comb begin
        count_upd = state.click_count;
        if (change && !button_level && state.click_count != CountMax) begin
            count_upd = state.click_count + CountW'(1);
        end
    end

    // an accepted change resets the elapsed time to zero, so no report then
    always_comb begin
        result.change = change;
        result.valid  = !change && (count_upd != '0)
                     && (elapsed > {{(TimeW-CfgW){1'b0}}, cfg.multi_click_max_ms});
        if (count_upd == CountW'(1)) begin
            result.kind = KIND_SINGLE;
        end else if (count_upd == CountW'(2)) begin
            result.kind = KIND_DOUBLE;
        end else begin
            result.kind = KIND_MULTI;
        end

        state_next.accepted_level   = change ? button_level : state.accepted_level;
        state_next.last_change_time = change ? now_ms : state.last_change_time;
        state_next.click_count      = result.valid ? '0 : count_upd;
    end

endmodule
